FILE: design/vlmra_pkg.sv
package vlmra_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int POOL_BYTES = 4096;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int OFF_W = 13;
	localparam int LEN_W = 13;
	localparam int BLK_W = 12;
	localparam int ST_W = 2;
	localparam int CMP_W = 17;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SLOT = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic accept;
		logic rel_take;
		logic wr_next;
	} dp_cmd_t;

	typedef struct packed {
		logic alloc_two;
		logic rel_busy;
	} dp_stat_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] n;
		if (s == SLOT_W'(SLOT_COUNT - 1)) begin
			n = '0;
		end else begin
			n = s + 1'b1;
		end
		return n;
	endfunction

endpackage

FILE: design/vlmra_ctrl.sv
module vlmra_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  vlmra_pkg::dp_stat_t stat,
	output vlmra_pkg::dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WR = 2'd1;
	localparam logic [1:0] S_RD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic       load_out;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept = in_valid && !in_stall;
	assign load_out = (accept && !stat.rel_busy) || (state_q == S_RD);

	assign cmd.accept = accept;
	assign cmd.wr_next = (state_q == S_WR);
	assign cmd.rel_take = (state_q == S_RD);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && stat.alloc_two) begin
					state_nx = S_WR;
				end else if (accept && stat.rel_busy) begin
					state_nx = S_RD;
				end
			end
			S_WR: state_nx = S_IDLE;
			S_RD: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/vlmra_dp.sv
module vlmra_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                operation,
	input  logic [vlmra_pkg::LEN_W-1:0]         request_length,
	input  vlmra_pkg::dp_cmd_t                  cmd,
	output vlmra_pkg::dp_stat_t                 stat,
	output logic [vlmra_pkg::ST_W-1:0]          status,
	output logic [vlmra_pkg::BLK_W-1:0]         block_offset,
	output logic                                not_empty,
	output logic [vlmra_pkg::OFF_W-1:0]         oldest_offset
);

	logic [vlmra_pkg::SLOT_W-1:0] head_q;
	logic [vlmra_pkg::SLOT_W-1:0] tail_q;
	logic [vlmra_pkg::OFF_W-1:0]  h_off_q;
	logic [vlmra_pkg::OFF_W-1:0]  t_off_q;
	logic [vlmra_pkg::SLOT_COUNT-1:0] vld_q;
	logic [vlmra_pkg::OFF_W-1:0]  mem_q [vlmra_pkg::SLOT_COUNT];
	logic [vlmra_pkg::OFF_W-1:0]  rd_data_q;
	logic                         rd_vld_q;
	logic [vlmra_pkg::SLOT_W-1:0] wr_addr_q;
	logic [vlmra_pkg::OFF_W-1:0]  wr_data_q;

	logic [vlmra_pkg::ST_W-1:0]   status_q;
	logic [vlmra_pkg::BLK_W-1:0]  block_offset_q;
	logic                         not_empty_q;
	logic [vlmra_pkg::OFF_W-1:0]  oldest_offset_q;

	logic [vlmra_pkg::SLOT_W-1:0] head_nx;
	logic [vlmra_pkg::SLOT_W-1:0] tail_nx;
	logic                         empty;
	logic                         full;
	logic                         is_rel;
	logic [vlmra_pkg::CMP_W-1:0]  h_ext;
	logic [vlmra_pkg::CMP_W-1:0]  t_ext;
	logic [vlmra_pkg::CMP_W-1:0]  len_ext;
	logic [vlmra_pkg::CMP_W-1:0]  pool_ext;
	logic                         fit_a;
	logic                         fit_b;
	logic                         fit_c;
	logic                         alloc_ok;
	logic [vlmra_pkg::OFF_W-1:0]  grant;
	logic [vlmra_pkg::OFF_W-1:0]  new_off;
	logic [vlmra_pkg::ST_W-1:0]   st_now;
	logic [vlmra_pkg::OFF_W-1:0]  rd_val;
	logic                         rel_ne;
	logic                         we;
	logic [vlmra_pkg::SLOT_W-1:0] waddr;
	logic [vlmra_pkg::OFF_W-1:0]  wdata;

	assign head_nx = vlmra_pkg::next_slot(head_q);
	assign tail_nx = vlmra_pkg::next_slot(tail_q);
	assign empty = (head_q == tail_q);
	assign full = (head_nx == tail_q);
	assign is_rel = (operation == vlmra_pkg::OP_RELEASE);

	assign h_ext = vlmra_pkg::CMP_W'(h_off_q);
	assign t_ext = vlmra_pkg::CMP_W'(t_off_q);
	assign len_ext = vlmra_pkg::CMP_W'(request_length);
	assign pool_ext = vlmra_pkg::CMP_W'(vlmra_pkg::POOL_BYTES);

	assign fit_a = (h_ext < t_ext) && ((t_ext - h_ext) > len_ext);
	assign fit_b = !(h_ext < t_ext) && (h_ext < pool_ext) && ((pool_ext - h_ext) > len_ext);
	assign fit_c = !(h_ext < t_ext) && !fit_b && (t_ext > len_ext);

	assign alloc_ok = !is_rel && !full && (fit_a || fit_b || fit_c);
	assign grant = fit_c ? '0 : h_off_q;
	assign new_off = vlmra_pkg::OFF_W'(vlmra_pkg::CMP_W'(grant) + len_ext);

	assign stat.alloc_two = alloc_ok;
	assign stat.rel_busy = is_rel && !empty;

	always_comb begin
		if (is_rel) begin
			st_now = vlmra_pkg::ST_EMPTY;
		end else if (full) begin
			st_now = vlmra_pkg::ST_NO_SLOT;
		end else if (alloc_ok) begin
			st_now = vlmra_pkg::ST_OK;
		end else begin
			st_now = vlmra_pkg::ST_NO_SPACE;
		end
	end

	assign rd_val = rd_vld_q ? rd_data_q : '0;
	assign rel_ne = (tail_q != head_q);

	assign we = (cmd.accept && alloc_ok) || cmd.wr_next;
	assign waddr = cmd.wr_next ? wr_addr_q : head_q;
	assign wdata = cmd.wr_next ? wr_data_q : grant;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			h_off_q <= '0;
			t_off_q <= '0;
			vld_q <= '0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cmd.accept && alloc_ok) begin
				head_q <= head_nx;
				h_off_q <= new_off;
				if (empty) begin
					t_off_q <= grant;
				end
			end
			if (cmd.accept && stat.rel_busy) begin
				tail_q <= tail_nx;
			end
			if (cmd.rel_take) begin
				t_off_q <= rd_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[tail_nx];
		rd_vld_q <= vld_q[tail_nx];
		if (cmd.accept) begin
			wr_addr_q <= head_nx;
			wr_data_q <= new_off;
		end
		if (cmd.accept && !stat.rel_busy) begin
			status_q <= st_now;
			block_offset_q <= alloc_ok ? grant[vlmra_pkg::BLK_W-1:0] : '0;
			not_empty_q <= alloc_ok || !empty;
			if (alloc_ok) begin
				oldest_offset_q <= empty ? grant : t_off_q;
			end else begin
				oldest_offset_q <= empty ? '0 : t_off_q;
			end
		end else if (cmd.rel_take) begin
			status_q <= vlmra_pkg::ST_OK;
			block_offset_q <= '0;
			not_empty_q <= rel_ne;
			oldest_offset_q <= rel_ne ? rd_val : '0;
		end
	end

	assign status = status_q;
	assign block_offset = block_offset_q;
	assign not_empty = not_empty_q;
	assign oldest_offset = oldest_offset_q;

endmodule

FILE: design/variable_length_message_ring_allocator.sv
// Allocates variable-length message blocks from a circular byte pool and retires them oldest
// first, with one result transaction for every request transaction. A refused allocation and a
// release on an empty ring do not hold the input, so the next request can be taken as soon as
// the result register is free. A granted allocation holds the input for its second table write
// because the 16-entry offset table has one write port and needs two writes. A release of a
// pending message also holds the input, for the registered table read of the new oldest offset.
// The result is registered. It appears in the cycle after the request is taken, or, for a
// release of a pending message, after the table read state. A new request is taken in the same
// cycle that the last result is drained, and a stalled result holds the input. The offset table
// uses per-entry valid flags cleared at reset, so no clearing pass is needed.
module variable_length_message_ring_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [vlmra_pkg::LEN_W-1:0]         request_length,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [vlmra_pkg::ST_W-1:0]          status,
	output logic [vlmra_pkg::BLK_W-1:0]         block_offset,
	output logic                                not_empty,
	output logic [vlmra_pkg::OFF_W-1:0]         oldest_offset
);

	vlmra_pkg::dp_cmd_t  cmd;
	vlmra_pkg::dp_stat_t stat;

	vlmra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	vlmra_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.request_length (request_length),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status),
		.block_offset   (block_offset),
		.not_empty      (not_empty),
		.oldest_offset  (oldest_offset)
	);

`ifndef NO_ASSERTIONS
	a_accept_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !(out_valid && out_stall))
		else $error("Request taken while the result register was blocked.");

	a_release_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && stat.rel_busy) |=> in_stall)
		else $error("Input not held during the table read of a release.");

	a_empty_no_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !not_empty) |-> (oldest_offset == '0))
		else $error("Oldest offset reported for an empty ring.");

	a_fail_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != vlmra_pkg::ST_OK)) |-> (block_offset == '0))
		else $error("Block offset reported for a refused request.");
`endif

endmodule
